@@ rtl/fst_pkg.sv @@
// Shared types and codes for the frequency-sorted insert table.
// Holds the stored entry layout, the result record and the operation codes.
// No dependencies.
`default_nettype none

package fst_pkg;

  // Operation codes carried in the request's tuser field.
  localparam logic [1:0] MODE_INSERT = 2'd0;
  localparam logic [1:0] MODE_READ   = 2'd1;
  localparam logic [1:0] MODE_CLEAR  = 2'd2;

  // One stored table entry.
  typedef struct packed {
    logic [31:0] freq;
    logic [7:0]  sym;
  } entry_t;

  // One result record as handed from the sequencer to the output stage.
  typedef struct packed {
    logic        full_drop;
    logic        valid_res;
    logic [8:0]  entry_total;
    logic [7:0]  position;
    logic [31:0] frequency;
    logic [7:0]  symbol;
  } res_t;

endpackage

`default_nettype wire

@@ rtl/fst_mem.sv @@
// Single-port-write, single-port-read table memory with a registered read.
// Stores fst_pkg::entry_t words; depends on fst_pkg.
`default_nettype none

module fst_mem #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  wire logic            clk,
  input  wire logic            wr_en,
  input  wire logic [AW-1:0]   wr_addr,
  input  wire fst_pkg::entry_t wr_data,
  input  wire logic            rd_en,
  input  wire logic [AW-1:0]   rd_addr,
  output fst_pkg::entry_t      rd_data
);
  import fst_pkg::*;

  entry_t mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port, registered.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

@@ rtl/fst_seq.sv @@
// Operation sequencer: keeps the entry count and walks the table memory
// from the top down to shift entries for an insert. Depends on fst_pkg.
`default_nettype none

module fst_seq #(
  parameter int MAX_ENTRIES = 256,
  parameter int AW          = 8,
  parameter int CW          = 9
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  // Request side
  input  wire logic            req_valid,
  output logic                 req_ready,
  input  wire logic [1:0]      req_mode,
  input  wire logic [7:0]      req_symbol,
  input  wire logic [31:0]     req_frequency,
  input  wire logic [7:0]      req_read_index,
  // Result side
  output logic                 res_valid,
  input  wire logic            res_ready,
  output fst_pkg::res_t        res,
  // Table memory
  output logic                 mem_wr_en,
  output logic [AW-1:0]        mem_wr_addr,
  output fst_pkg::entry_t      mem_wr_data,
  output logic                 mem_rd_en,
  output logic [AW-1:0]        mem_rd_addr,
  input  wire fst_pkg::entry_t mem_rd_data
);
  import fst_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_CMP   = 5'b00010,
    S_PUT   = 5'b00100,
    S_FETCH = 5'b01000,
    S_EMIT  = 5'b10000
  } state_t;

  state_t         state_r, state_nxt;
  logic [CW-1:0]  count_r, count_nxt;
  logic [AW-1:0]  idx_r, idx_nxt;
  logic [7:0]     sym_r, sym_nxt;
  logic [31:0]    freq_r, freq_nxt;
  logic [7:0]     ridx_r, ridx_nxt;
  res_t           res_r, res_nxt;

  logic [AW-1:0]  idx_inc;
  logic [CW-1:0]  count_inc;
  entry_t         new_entry;

  assign idx_inc   = idx_r + AW'(1);
  assign count_inc = count_r + CW'(1);
  assign new_entry = '{freq: freq_r, sym: sym_r};

  assign req_ready = (state_r == S_IDLE);
  assign res_valid = (state_r == S_EMIT);
  assign res       = res_r;

  // Next-state and datapath control.
  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    idx_nxt     = idx_r;
    sym_nxt     = sym_r;
    freq_nxt    = freq_r;
    ridx_nxt    = ridx_r;
    res_nxt     = res_r;
    mem_wr_en   = 1'b0;
    mem_wr_addr = idx_inc;
    mem_wr_data = new_entry;
    mem_rd_en   = 1'b0;
    mem_rd_addr = idx_r;

    unique case (state_r)
      S_IDLE: begin
        if (req_valid) begin
          sym_nxt  = req_symbol;
          freq_nxt = req_frequency;
          ridx_nxt = req_read_index;
          res_nxt  = '0;
          case (req_mode)
            MODE_INSERT: begin
              if (count_r >= CW'(MAX_ENTRIES)) begin
                // Full table: drop the pair and flag it.
                res_nxt.entry_total = 9'(count_r);
                res_nxt.full_drop   = 1'b1;
                state_nxt           = S_EMIT;
              end else if (count_r == '0) begin
                idx_nxt   = '0;
                state_nxt = S_PUT;
              end else begin
                // Start the downward walk at the topmost entry.
                idx_nxt     = AW'(count_r - CW'(1));
                mem_rd_en   = 1'b1;
                mem_rd_addr = AW'(count_r - CW'(1));
                state_nxt   = S_CMP;
              end
            end
            MODE_READ: begin
              // An index at or past the count answers at once with no data.
              res_nxt.position    = req_read_index;
              res_nxt.entry_total = 9'(count_r);
              if (int'(req_read_index) < int'(count_r)) begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = AW'(req_read_index);
                state_nxt   = S_FETCH;
              end else begin
                state_nxt = S_EMIT;
              end
            end
            MODE_CLEAR: begin
              count_nxt = '0;
              state_nxt = S_EMIT;
            end
            default: begin
              res_nxt.entry_total = 9'(count_r);
              state_nxt           = S_EMIT;
            end
          endcase
        end
      end

      S_CMP: begin
        mem_wr_en = 1'b1;
        if (mem_rd_data.freq > freq_r) begin
          // Entry moves up one place; keep walking down.
          mem_wr_data = mem_rd_data;
          if (idx_r == '0) begin
            state_nxt = S_PUT;
          end else begin
            idx_nxt     = idx_r - AW'(1);
            mem_rd_en   = 1'b1;
            mem_rd_addr = idx_r - AW'(1);
          end
        end else begin
          // New pair lands just above the first entry not larger than it.
          count_nxt           = count_inc;
          res_nxt.symbol      = sym_r;
          res_nxt.frequency   = freq_r;
          res_nxt.position    = 8'(idx_inc);
          res_nxt.entry_total = 9'(count_inc);
          res_nxt.valid_res   = 1'b1;
          state_nxt           = S_EMIT;
        end
      end

      S_PUT: begin
        mem_wr_en           = 1'b1;
        mem_wr_addr         = idx_r;
        count_nxt           = count_inc;
        res_nxt.symbol      = sym_r;
        res_nxt.frequency   = freq_r;
        res_nxt.position    = 8'(idx_r);
        res_nxt.entry_total = 9'(count_inc);
        res_nxt.valid_res   = 1'b1;
        state_nxt           = S_EMIT;
      end

      S_FETCH: begin
        res_nxt.symbol      = mem_rd_data.sym;
        res_nxt.frequency   = mem_rd_data.freq;
        res_nxt.position    = ridx_r;
        res_nxt.entry_total = 9'(count_r);
        res_nxt.valid_res   = 1'b1;
        state_nxt           = S_EMIT;
      end

      S_EMIT: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    idx_r  <= idx_nxt;
    sym_r  <= sym_nxt;
    freq_r <= freq_nxt;
    ridx_r <= ridx_nxt;
    res_r  <= res_nxt;
  end

endmodule

`default_nettype wire

@@ rtl/fst_out.sv @@
// Output register stage: holds one finished result on the master stream
// so the sequencer can take the next request. Depends on fst_pkg.
`default_nettype none

module fst_out (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          res_valid,
  output logic               res_ready,
  input  wire fst_pkg::res_t res,
  output logic               out_tvalid,
  input  wire logic          out_tready,
  output logic [63:0]        out_tdata,  // out_symbol, out_frequency, position, entry_total
  output logic [1:0]         out_tuser   // valid_res, full_drop
);
  import fst_pkg::*;

  logic  valid_r;
  res_t  data_r;

  assign res_ready  = !valid_r || out_tready;
  assign out_tvalid = valid_r;
  assign out_tdata  = {7'd0, data_r.entry_total, data_r.position,
                       data_r.frequency, data_r.symbol};
  assign out_tuser  = {data_r.full_drop, data_r.valid_res};

  // Valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (res_ready) begin
      valid_r <= res_valid;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      data_r <= res;
    end
  end

endmodule

`default_nettype wire

@@ rtl/frequency_sorted_insert_table.sv @@
// Frequency-sorted insert table: keeps up to MAX_ENTRIES (symbol, frequency)
// pairs in ascending frequency order, ties in arrival order, in one table
// memory with a registered read. One request at a time is worked on. An
// insert walks the table from the topmost entry down, one entry per cycle,
// moving each larger entry up one place, as the memory has a single read
// and a single write port. A read of a stored entry fetches it from the
// memory; a clear, a dropped insert, a read past the count and an unused
// code answer at once. A finished result waits in an output register, so
// the next request is taken while the result is still stalled.
// Depends on fst_pkg, fst_seq, fst_mem and fst_out.
`default_nettype none

module frequency_sorted_insert_table #(
  parameter int MAX_ENTRIES = 256
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [47:0]  in_tdata,   // symbol, frequency, read_index
  input  wire logic [1:0]   in_tuser,   // mode
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [63:0]       out_tdata,  // out_symbol, out_frequency, position, entry_total
  output logic [1:0]        out_tuser   // valid_res, full_drop
);
  import fst_pkg::*;

  localparam int AW = $clog2(MAX_ENTRIES);
  localparam int CW = $clog2(MAX_ENTRIES + 1);

  logic           res_valid;
  logic           res_ready;
  res_t           res;
  logic           mem_wr_en;
  logic [AW-1:0]  mem_wr_addr;
  entry_t         mem_wr_data;
  logic           mem_rd_en;
  logic [AW-1:0]  mem_rd_addr;
  entry_t         mem_rd_data;

  // Operation sequencer and entry count.
  fst_seq #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .AW          (AW),
    .CW          (CW)
  ) u_seq (
    .clk            (clk),
    .rst_n          (rst_n),
    .req_valid      (in_tvalid),
    .req_ready      (in_tready),
    .req_mode       (in_tuser),
    .req_symbol     (in_tdata[7:0]),
    .req_frequency  (in_tdata[39:8]),
    .req_read_index (in_tdata[47:40]),
    .res_valid      (res_valid),
    .res_ready      (res_ready),
    .res            (res),
    .mem_wr_en      (mem_wr_en),
    .mem_wr_addr    (mem_wr_addr),
    .mem_wr_data    (mem_wr_data),
    .mem_rd_en      (mem_rd_en),
    .mem_rd_addr    (mem_rd_addr),
    .mem_rd_data    (mem_rd_data)
  );

  // Table memory.
  fst_mem #(
    .DEPTH (MAX_ENTRIES),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  // Result register toward the master stream.
  fst_out u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

`default_nettype wire
